FILE: hdl/assert_macros.svh
// Assertion macros for the checker file, bdll_checker.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bdll_pkg.sv
// Package for the bounded doubly linked list: widths, codes and cell control.
// Used by bdll_cell, bounded_doubly_linked_list and bdll_checker.
package bdll_pkg;

  localparam int BDLL_CAPACITY = 16;
  localparam int KIND_W        = 3;
  localparam int WORD_W        = 32;
  localparam int SIZE_W        = 7;
  localparam int STATUS_W      = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_REM_FRONT  = 3'd2,
    KIND_REM_BACK   = 3'd3,
    KIND_INSERT     = 3'd4,
    KIND_READ_ALL   = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_SHL,
    CELL_ROT
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  // Broadcast to every cell each cycle.
  typedef struct packed {
    cell_op_e                 op;
    logic [SIZE_W-1:0]        ins_idx;   // slot that loads the new word
    logic [SIZE_W-1:0]        last_idx;  // slot of the tail element
    logic signed [WORD_W-1:0] data;
  } cell_ctrl_t;

endpackage

FILE: hdl/bounded_doubly_linked_list.sv
// Bounded ordered list of signed 32-bit words, held as a row of CAPACITY slot cells
// in list order. Depends on bdll_pkg and bdll_cell.
//
// Push, remove and insert give one result in the cycle after start is taken; busy
// stays low, so a new item may start on the very next cycle.
// Read all gives one result per element on consecutive cycles by rotating the
// occupied cells once around; busy stays high while the elements after the first
// are read out. Results are shown for one cycle under result_valid_o and the
// receiver cannot stall them.
module bounded_doubly_linked_list import bdll_pkg::*; #(
  parameter int CAPACITY = BDLL_CAPACITY
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [KIND_W-1:0]        kind_i,
  input  logic signed [WORD_W-1:0] data_word_i,
  input  logic [SIZE_W-1:0]        position_i,
  output logic                     result_valid_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic signed [WORD_W-1:0] read_word_o,
  output logic [SIZE_W-1:0]        list_size_o,
  output logic                     last_o
);

  localparam logic [SIZE_W-1:0] CapSize = SIZE_W'(CAPACITY);
  localparam logic [SIZE_W-1:0] One     = SIZE_W'(1);

  state_e                   state_d, state_q;
  logic [SIZE_W-1:0]        count_d, count_q;
  logic [SIZE_W-1:0]        rd_cnt_d, rd_cnt_q;
  logic                     strobe_d, strobe_q;
  status_e                  status_d, status_q;
  logic signed [WORD_W-1:0] word_d, word_q;
  logic                     last_d, last_q;
  logic                     accept;
  cell_ctrl_t               ctrl;
  logic signed [WORD_W-1:0] cell_val [CAPACITY];

  assign busy   = (state_q == ST_READ);
  assign accept = start && !busy;

  // Row of slot cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_W-1:0] left_val, right_val;
    if (i == 0) begin : g_first
      assign left_val = data_word_i;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end
    bdll_cell #(.CELL_IDX(i)) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left_val),
      .right_i (right_val),
      .head_i  (cell_val[0]),
      .value_o (cell_val[i])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (kind_i == KIND_READ_ALL) && (count_q > One)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_cnt_q == count_q - One) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Cell control and results
  always_comb begin
    ctrl.op       = CELL_HOLD;
    ctrl.ins_idx  = '0;
    ctrl.last_idx = count_q - One;
    ctrl.data     = data_word_i;
    count_d       = count_q;
    rd_cnt_d      = rd_cnt_q;
    strobe_d      = 1'b0;
    status_d      = STAT_OK;
    word_d        = '0;
    last_d        = 1'b1;
    case (state_q)
      ST_READ: begin
        ctrl.op  = CELL_ROT;
        strobe_d = 1'b1;
        word_d   = cell_val[0];
        rd_cnt_d = rd_cnt_q + One;
        last_d   = (rd_cnt_q == count_q - One);
      end
      ST_IDLE: begin
        if (accept) begin
          strobe_d = 1'b1;
          case (kind_i)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
              if (count_q == CapSize) begin
                status_d = STAT_FULL;
              end else begin
                ctrl.op      = CELL_INS;
                ctrl.ins_idx = (kind_i == KIND_PUSH_FRONT) ? '0 : count_q;
                count_d      = count_q + One;
              end
            end
            KIND_REM_FRONT, KIND_REM_BACK: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                // dropping the back only shortens the count
                if (kind_i == KIND_REM_FRONT) begin
                  ctrl.op = CELL_SHL;
                end
                count_d = count_q - One;
              end
            end
            KIND_INSERT: begin
              if ((position_i == '0) || (position_i > count_q)) begin
                status_d = STAT_RANGE;
              end else if (count_q == CapSize) begin
                status_d = STAT_FULL;
              end else begin
                ctrl.op      = CELL_INS;
                ctrl.ins_idx = position_i;
                count_d      = count_q + One;
              end
            end
            KIND_READ_ALL: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                ctrl.op  = CELL_ROT;
                word_d   = cell_val[0];
                rd_cnt_d = One;
                last_d   = (count_q == One);
              end
            end
            default: begin
              status_d = STAT_RANGE;
            end
          endcase
        end
      end
      default: begin
        strobe_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      rd_cnt_q <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_cnt_q <= rd_cnt_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    word_q   <= word_d;
    last_q   <= last_d;
  end

  // list_size follows the count register, which moves with the result
  assign result_valid_o = strobe_q;
  assign status_o       = status_q;
  assign read_word_o    = word_q;
  assign list_size_o    = count_q;
  assign last_o         = last_q;

endmodule

FILE: hdl/bdll_cell.sv
// One slot of the list: holds the element at a fixed position front to back.
// Depends on bdll_pkg; neighbors hand values left or right on shifts.
module bdll_cell import bdll_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [WORD_W-1:0] left_i,
  input  logic signed [WORD_W-1:0] right_i,
  input  logic signed [WORD_W-1:0] head_i,
  output logic signed [WORD_W-1:0] value_o
);

  localparam logic [SIZE_W-1:0] MyIdx = SIZE_W'(CELL_IDX);

  logic signed [WORD_W-1:0] val_d, val_q;

  always_comb begin
    val_d = val_q;
    case (ctrl_i.op)
      CELL_INS: begin
        // make room: slots past the insert point take from the left
        if (MyIdx == ctrl_i.ins_idx) begin
          val_d = ctrl_i.data;
        end else if (MyIdx > ctrl_i.ins_idx) begin
          val_d = left_i;
        end
      end
      CELL_SHL: begin
        val_d = right_i;
      end
      CELL_ROT: begin
        // rotate the occupied slots; the tail slot wraps the head around
        if (MyIdx == ctrl_i.last_idx) begin
          val_d = head_i;
        end else if (MyIdx < ctrl_i.last_idx) begin
          val_d = right_i;
        end
      end
      default: begin
        val_d = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign value_o = val_q;

endmodule

FILE: hdl/bdll_checker.sv
// Port-level checks for bounded_doubly_linked_list, bound to the top level.
// Depends on bdll_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bdll_checker import bdll_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic                     busy,
  input logic                     result_valid_o,
  input logic [STATUS_W-1:0]      status_o,
  input logic signed [WORD_W-1:0] read_word_o,
  input logic                     last_o
);

  // every taken item shows a result on the next cycle
  `ASSERT_NEXT(a_accept_result, start && !busy, result_valid_o, "item gave no result")
  // a read in progress emits an element every cycle
  `ASSERT_NEXT(a_busy_stream, busy, result_valid_o, "gap in read stream")
  // only a read that continues leaves last low
  `ASSERT_ALWAYS(a_mid_busy, !(result_valid_o && !last_o) || busy, "early last low")
  // non-ok results are single, carry no word
  `ASSERT_ALWAYS(a_err_clean,
    !(result_valid_o && (status_o != STAT_OK)) || (last_o && (read_word_o == '0)),
    "bad error result")

endmodule

bind bounded_doubly_linked_list bdll_checker u_bdll_checker (.*);
